// ===== sv/isoep_pkg.sv =====
// ----------------------------------------------------------------------------
// isoep_pkg
// Shared types, widths and tables for the timestamp text to epoch converter.
// ----------------------------------------------------------------------------
package isoep_pkg;

  localparam int unsigned EpochW  = 50;
  localparam int unsigned YearW   = 14;
  localparam int unsigned FieldW  = 7;
  localparam int unsigned MillisW = 10;

  // fields collected by the parser, handed to the conversion datapath
  typedef struct packed {
    logic               ok;
    logic [YearW-1:0]   year;
    logic [FieldW-1:0]  month;
    logic [FieldW-1:0]  day;
    logic [FieldW-1:0]  hour;
    logic [FieldW-1:0]  minute;
    logic [FieldW-1:0]  second;
    logic [MillisW-1:0] millis;
    logic               zone_neg;
    logic [FieldW-1:0]  zone_hours;
    logic [FieldW-1:0]  zone_minutes;
  } parse_fields_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic char_en;
    logic clear;
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_d;
    logic ld_e;
    logic ld_f;
    logic ld_g;
    logic ld_out;
  } ctrl_cmd_t;

  // days from march 1 to the first of the month, march-based month index
  function automatic logic [8:0] doy_of(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/isoep_parse.sv =====
// ----------------------------------------------------------------------------
// isoep_parse
// Character decoder: checks the fixed date/time form, collects the fraction
// and zone, and keeps the decimal field accumulators.
// ----------------------------------------------------------------------------
module isoep_parse (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  isoep_pkg::ctrl_cmd_t   cmd_i,
  input  logic [7:0]             ch_i,
  output isoep_pkg::parse_fields_t fields_o
);

  typedef enum logic [8:0] {
    PH_FIXED  = 9'b000000001,
    PH_AFTER  = 9'b000000010,
    PH_FRAC   = 9'b000000100,
    PH_ZH1    = 9'b000001000,
    PH_ZH2    = 9'b000010000,
    PH_ZAFTER = 9'b000100000,
    PH_ZCOLON = 9'b001000000,
    PH_ZM2    = 9'b010000000,
    PH_DONE   = 9'b100000000
  } phase_e;

  localparam logic [7:0] ChPlus  = 8'd43;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] ChDot   = 8'd46;
  localparam logic [7:0] ChColon = 8'd58;
  localparam logic [7:0] ChUpT   = 8'd84;
  localparam logic [7:0] ChLowT  = 8'd116;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [4:0] IdxMax  = 5'd31;
  localparam logic [4:0] IdxEnd  = 5'd18;

  function automatic logic [6:0] acc2(input logic [6:0] a, input logic [3:0] d);
    logic [9:0] s;
    s = {a, 3'b000} + {2'b00, a, 1'b0} + {6'b000000, d};
    return s[6:0];
  endfunction

  phase_e      phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic        failed_q, failed_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d, day_q, day_d;
  logic [6:0]  hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  logic [9:0]  millis_q, millis_d;
  logic [1:0]  fplace_q, fplace_d;
  logic        zneg_q, zneg_d;
  logic [6:0]  zh_q, zh_d, zm_q, zm_d;

  logic        dig, sign;
  logic [3:0]  dval;
  logic [16:0] year_sum;

  assign dig      = ch_i inside {[8'd48:8'd57]};
  assign sign     = (ch_i == ChPlus) || (ch_i == ChMinus);
  assign dval     = ch_i[3:0];
  assign year_sum = {year_q, 3'b000} + {2'b00, year_q, 1'b0} + {13'd0, dval};

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    failed_d = failed_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    millis_d = millis_q;
    fplace_d = fplace_q;
    zneg_d   = zneg_q;
    zh_d     = zh_q;
    zm_d     = zm_q;
    if (cmd_i.clear) begin
      phase_d  = PH_FIXED;
      idx_d    = '0;
      failed_d = 1'b0;
      year_d   = '0;
      month_d  = '0;
      day_d    = '0;
      hour_d   = '0;
      minute_d = '0;
      second_d = '0;
      millis_d = '0;
      fplace_d = '0;
      zneg_d   = 1'b0;
      zh_d     = '0;
      zm_d     = '0;
    end else if (cmd_i.char_en) begin
      if (!failed_q) begin
        if (phase_q == PH_FIXED) begin
          if (idx_q inside {[5'd0:5'd3]}) begin
            if (dig) year_d = year_sum[13:0];
            else failed_d = 1'b1;
          end else if (idx_q inside {5'd4, 5'd7}) begin
            if (ch_i != ChMinus) failed_d = 1'b1;
          end else if (idx_q inside {[5'd5:5'd6]}) begin
            if (dig) month_d = acc2(month_q, dval);
            else failed_d = 1'b1;
          end else if (idx_q inside {[5'd8:5'd9]}) begin
            if (dig) day_d = acc2(day_q, dval);
            else failed_d = 1'b1;
          end else if (idx_q == 5'd10) begin
            if (ch_i != ChUpT && ch_i != ChLowT && ch_i != ChSpace) failed_d = 1'b1;
          end else if (idx_q inside {5'd13, 5'd16}) begin
            if (ch_i != ChColon) failed_d = 1'b1;
          end else if (idx_q inside {[5'd11:5'd12]}) begin
            if (dig) hour_d = acc2(hour_q, dval);
            else failed_d = 1'b1;
          end else if (idx_q inside {[5'd14:5'd15]}) begin
            if (dig) minute_d = acc2(minute_q, dval);
            else failed_d = 1'b1;
          end else begin
            if (dig) second_d = acc2(second_q, dval);
            else failed_d = 1'b1;
          end
          if (idx_q == IdxEnd) phase_d = PH_AFTER;
        end else begin
          case (phase_q)
            PH_AFTER: begin
              if (ch_i == ChDot) begin
                phase_d = PH_FRAC;
              end else if (sign) begin
                zneg_d  = (ch_i == ChMinus);
                phase_d = PH_ZH1;
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_FRAC: begin
              if (dig) begin
                case (fplace_q)
                  2'd0:    millis_d = millis_q + 10'({6'd0, dval} * 10'd100);
                  2'd1:    millis_d = millis_q + 10'({6'd0, dval} * 10'd10);
                  2'd2:    millis_d = millis_q + {6'd0, dval};
                  default: millis_d = millis_q;
                endcase
                if (fplace_q != 2'd3) fplace_d = fplace_q + 2'd1;
              end else if (sign) begin
                zneg_d  = (ch_i == ChMinus);
                phase_d = PH_ZH1;
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_ZH1, PH_ZH2: begin
              if (dig) begin
                zh_d    = acc2(zh_q, dval);
                phase_d = (phase_q == PH_ZH1) ? PH_ZH2 : PH_ZAFTER;
              end else begin
                failed_d = 1'b1;
              end
            end
            PH_ZAFTER, PH_ZCOLON: begin
              if (dig) begin
                zm_d    = acc2(zm_q, dval);
                phase_d = PH_ZM2;
              end else if (ch_i == ChColon && phase_q == PH_ZAFTER) begin
                phase_d = PH_ZCOLON;
              end else begin
                phase_d = PH_DONE;
              end
            end
            PH_ZM2: begin
              if (dig) begin
                zm_d    = acc2(zm_q, dval);
                phase_d = PH_DONE;
              end else begin
                failed_d = 1'b1;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
      if (idx_q != IdxMax) idx_d = idx_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIXED;
      idx_q    <= '0;
      failed_q <= 1'b0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      millis_q <= '0;
      fplace_q <= '0;
      zneg_q   <= 1'b0;
      zh_q     <= '0;
      zm_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      failed_q <= failed_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      millis_q <= millis_d;
      fplace_q <= fplace_d;
      zneg_q   <= zneg_d;
      zh_q     <= zh_d;
      zm_q     <= zm_d;
    end
  end

  // string is complete unless still inside the fixed part or a partial zone
  assign fields_o.ok = !failed_q && (phase_q == PH_AFTER || phase_q == PH_FRAC ||
                       phase_q == PH_ZAFTER || phase_q == PH_ZCOLON || phase_q == PH_DONE);
  assign fields_o.year         = year_q;
  assign fields_o.month        = month_q;
  assign fields_o.day          = day_q;
  assign fields_o.hour         = hour_q;
  assign fields_o.minute       = minute_q;
  assign fields_o.second       = second_q;
  assign fields_o.millis       = millis_q;
  assign fields_o.zone_neg     = zneg_q;
  assign fields_o.zone_hours   = zh_q;
  assign fields_o.zone_minutes = zm_q;

endmodule

// ===== sv/isoep_conv.sv =====
// ----------------------------------------------------------------------------
// isoep_conv
// Conversion datapath: month normalization, days from civil date, seconds,
// zone offset and milliseconds, one step per command, plus the result register.
// ----------------------------------------------------------------------------
module isoep_conv (
  input  logic                      clk_i,
  input  isoep_pkg::ctrl_cmd_t      cmd_i,
  input  isoep_pkg::parse_fields_t  fields_i,
  output logic                      valid_res_o,
  output logic signed [isoep_pkg::EpochW-1:0] epoch_ms_o
);

  // step a: year shifted up by one 400-year era, march-based month
  logic [6:0]  mm1;
  logic [14:0] mq_prod;
  logic [3:0]  mq;
  logic [6:0]  mr_full;
  logic [3:0]  mr;
  logic        mr_hi;
  logic [14:0] yp_d, yp_q;
  logic [3:0]  mp_d, mp_q;
  isoep_pkg::parse_fields_t f_q;

  assign mm1     = fields_i.month - 7'd1;
  assign mq_prod = {8'd0, mm1} * 15'd171;  // month-1 divided by 12
  assign mq      = mq_prod[14:11];
  assign mr_full = mm1 - 7'({3'd0, mq} * 7'd12);
  assign mr      = mr_full[3:0];
  assign mr_hi   = (mr >= 4'd2);

  always_comb begin
    if (fields_i.month == 7'd0) begin
      // month zero rolls back into december of the year before
      yp_d = {1'b0, fields_i.year} + 15'd399;
      mp_d = 4'd9;
    end else begin
      yp_d = {1'b0, fields_i.year} + 15'd399 + {11'd0, mq} + {14'd0, mr_hi};
      mp_d = mr_hi ? (mr - 4'd2) : (mr + 4'd10);
    end
  end

  // step b: era index and time of day
  logic [20:0] era_prod;
  logic [5:0]  era_q;
  logic [18:0] hms_q;
  assign era_prod = {10'd0, yp_q[14:4]} * 21'd1311;  // divide by 400

  // step c: year of era and zone offset
  logic [14:0] yoe_full;
  logic [8:0]  yoe_q;
  logic [18:0] off_q;
  assign yoe_full = yp_q - 15'({9'd0, era_q} * 15'd400);

  // step d: day of era
  logic [1:0]  c100;
  logic [17:0] doe_d, doe_q;
  always_comb begin
    if (yoe_q >= 9'd300)      c100 = 2'd3;
    else if (yoe_q >= 9'd200) c100 = 2'd2;
    else if (yoe_q >= 9'd100) c100 = 2'd1;
    else                      c100 = 2'd0;
  end
  assign doe_d = 18'({9'd0, yoe_q} * 18'd365) + {11'd0, yoe_q[8:2]} - {16'd0, c100}
               + {9'd0, isoep_pkg::doy_of(mp_q)};

  // step e: days since 1970, era counted from one below the real one
  logic [23:0]        days_u;
  logic signed [24:0] days_q;
  assign days_u = 24'({18'd0, era_q} * 24'd146097) + {6'd0, doe_q} + {17'd0, f_q.day};

  // step f: seconds
  logic signed [41:0] days_x, secs_q;
  assign days_x = 42'(days_q);

  // step g: apply zone, flag the minus one second instant
  logic signed [41:0] off_x, diff_q;
  logic               neg1_q;
  assign off_x = $signed({23'd0, off_q});

  // output: times 1000 as shifts, plus milliseconds
  logic signed [49:0] diff50, ms50;
  logic               res_ok;
  assign diff50 = 50'(diff_q);
  assign ms50   = (diff50 <<< 10) - (diff50 <<< 4) - (diff50 <<< 3) + $signed({40'd0, f_q.millis});
  assign res_ok = f_q.ok && !neg1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) begin
      yp_q <= yp_d;
      mp_q <= mp_d;
      f_q  <= fields_i;
    end
    if (cmd_i.ld_b) begin
      era_q <= era_prod[20:15];
      hms_q <= 19'({12'd0, f_q.hour} * 19'd3600) + 19'({12'd0, f_q.minute} * 19'd60)
             + {12'd0, f_q.second};
    end
    if (cmd_i.ld_c) begin
      yoe_q <= yoe_full[8:0];
      off_q <= 19'({12'd0, f_q.zone_hours} * 19'd3600)
             + 19'({12'd0, f_q.zone_minutes} * 19'd60);
    end
    if (cmd_i.ld_d) begin
      doe_q <= doe_d;
    end
    if (cmd_i.ld_e) begin
      days_q <= $signed({1'b0, days_u}) - 25'sd865566;
    end
    if (cmd_i.ld_f) begin
      secs_q <= days_x * 42'sd86400 + $signed({23'd0, hms_q});
    end
    if (cmd_i.ld_g) begin
      neg1_q <= (secs_q == -42'sd1);
      diff_q <= f_q.zone_neg ? (secs_q + off_x) : (secs_q - off_x);
    end
    if (cmd_i.ld_out) begin
      valid_res_o <= res_ok;
      epoch_ms_o  <= res_ok ? ms50 : '1;
    end
  end

endmodule

// ===== sv/isoep_ctrl.sv =====
// ----------------------------------------------------------------------------
// isoep_ctrl
// Controller: takes characters, then steps the conversion datapath and owns
// the output handshake.
// ----------------------------------------------------------------------------
module isoep_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 last_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output isoep_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_PARSE = 9'b000000001,
    ST_A     = 9'b000000010,
    ST_B     = 9'b000000100,
    ST_C     = 9'b000001000,
    ST_D     = 9'b000010000,
    ST_E     = 9'b000100000,
    ST_F     = 9'b001000000,
    ST_G     = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, out_free;

  assign accept   = in_valid_i && (state_q == ST_PARSE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_PARSE: if (accept && last_i) state_d = ST_A;
      ST_A:     state_d = ST_B;
      ST_B:     state_d = ST_C;
      ST_C:     state_d = ST_D;
      ST_D:     state_d = ST_E;
      ST_E:     state_d = ST_F;
      ST_F:     state_d = ST_G;
      ST_G:     state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_PARSE;
      default:  state_d = ST_PARSE;
    endcase
  end

  always_comb begin
    cmd_o.char_en = accept;
    cmd_o.clear   = (state_q == ST_A);
    cmd_o.ld_a    = (state_q == ST_A);
    cmd_o.ld_b    = (state_q == ST_B);
    cmd_o.ld_c    = (state_q == ST_C);
    cmd_o.ld_d    = (state_q == ST_D);
    cmd_o.ld_e    = (state_q == ST_E);
    cmd_o.ld_f    = (state_q == ST_F);
    cmd_o.ld_g    = (state_q == ST_G);
    cmd_o.ld_out  = (state_q == ST_OUT) && out_free;
  end

  // result stays until taken, a new one may replace it in the same cycle
  assign out_valid_d = cmd_o.ld_out ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_PARSE);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_last_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> (state_q == ST_A))
    else $error("last character did not start conversion");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_wait_for_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && out_stall_i) |=> (state_q == ST_OUT))
    else $error("result overwrote a pending request");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule

// ===== sv/iso8601_text_to_epoch_ms_top.sv =====
// ----------------------------------------------------------------------------
// iso8601_text_to_epoch_ms_top
// ISO 8601 timestamp text, one character per request, to epoch milliseconds.
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  --------+------------------------------+-------------------------------
//  in      | in_valid_i  / in_stall_o     | ch_i[7:0], last_i
//  out     | out_valid_o / out_stall_i    | valid_res_o, epoch_ms_o[49:0]
//
// one character is taken per cycle while the string streams in.
// after the last character the conversion sequencer steps through normalize,
// era, year of era, day of era, days, seconds, zone and output load; input
// stalls meanwhile. the output register holds its result while out_stall_i
// is high, and the output load waits for it. asynchronous reset returns
// parser and controller to the start of a string.
// ----------------------------------------------------------------------------
module iso8601_text_to_epoch_ms_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          ch_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                valid_res_o,
  output logic signed [isoep_pkg::EpochW-1:0] epoch_ms_o
);

  isoep_pkg::ctrl_cmd_t     cmd;
  isoep_pkg::parse_fields_t fields;

  isoep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  isoep_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .ch_i     (ch_i),
    .fields_o (fields)
  );

  isoep_conv u_conv (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .fields_i    (fields),
    .valid_res_o (valid_res_o),
    .epoch_ms_o  (epoch_ms_o)
  );

endmodule

// ===== tb/iso8601_text_to_epoch_ms_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_text_to_epoch_ms_top_tb
// Streams timestamp strings one character per request into the converter.
// Each character also feeds a parser model kept here, which queues the epoch
// value due at the end of each string. Every result that comes out is checked
// against the oldest queued value. Both sides idle and stall at random, and
// one long output hold makes the block back up its input.
// ----------------------------------------------------------------------------
module iso8601_text_to_epoch_ms_top_tb;

  localparam int unsigned EpW            = isoep_pkg::EpochW;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          RAND_CHARS     = 120;
  localparam int          RAND_STAMPS    = 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T_UP  = 8'h54;
  localparam logic [7:0] CH_T_LO  = 8'h74;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;

  typedef enum int {
    PH_FIXED,
    PH_AFTER_SEC,
    PH_FRACTION,
    PH_ZONE_H1,
    PH_ZONE_H2,
    PH_ZONE_SEP,
    PH_ZONE_M1,
    PH_ZONE_M2,
    PH_IGNORE
  } parse_phase_e;

  typedef struct packed {
    logic                  ok;
    logic signed [EpW-1:0] ms;
  } epoch_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            ch_i;
  logic                  last_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  valid_res_o;
  logic signed [EpW-1:0] epoch_ms_o;

  iso8601_text_to_epoch_ms_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .valid_res_o (valid_res_o),
    .epoch_ms_o  (epoch_ms_o)
  );

  // parser model state
  int unsigned   p_pos;
  parse_phase_e  p_phase;
  bit            p_failed;
  logic [13:0]   p_year;
  logic [6:0]    p_month, p_day, p_hour, p_minute, p_second;
  logic [9:0]    p_millis;
  logic [1:0]    p_place;
  bit            p_zneg;
  logic [6:0]    p_zhours, p_zminutes;

  epoch_result_t pending_stamps[$];
  epoch_result_t seen_want;
  logic [7:0]    text_q[$];
  int            err_count;
  int            idle_cycles;
  bit            quiet;
  bit            hold_req;
  bit            hold_active;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [6:0] shift_in_digit(logic [6:0] acc, int unsigned v);
    return 7'(acc * 10 + v);
  endfunction

  function automatic longint days_from_civil(longint y, longint m, longint d);
    longint yy, era, yoe, doy, doe, mp;
    yy = (m <= 2) ? y - 1 : y;
    era = (yy >= 0 ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    mp = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // timegm-style: month rolls into year linearly, day/time just add up
  function automatic bit epoch_from_fields(output longint ms);
    longint y, m0, d, h, mi, s, frac, zh, zm, days, secs, off;
    y = p_year;
    m0 = p_month;
    d = p_day;
    h = p_hour;
    mi = p_minute;
    s = p_second;
    frac = p_millis;
    zh = p_zhours;
    zm = p_zminutes;
    m0 = m0 - 1;
    if (m0 < 0) begin
      y = y - 1;
      m0 = m0 + 12;
    end else begin
      y = y + m0 / 12;
      m0 = m0 % 12;
    end
    days = days_from_civil(y, m0 + 1, 1) + d - 1;
    secs = days * 86400 + h * 3600 + mi * 60 + s;
    ms = -1;
    if (secs == -1) return 1'b0;
    off = zh * 3600 + zm * 60;
    if (p_zneg) off = -off;
    ms = (secs - off) * 1000 + frac;
    return 1'b1;
  endfunction

  task automatic clear_parser();
    p_pos = 0;
    p_phase = PH_FIXED;
    p_failed = 1'b0;
    p_year = '0;
    p_month = '0;
    p_day = '0;
    p_hour = '0;
    p_minute = '0;
    p_second = '0;
    p_millis = '0;
    p_place = '0;
    p_zneg = 1'b0;
    p_zhours = '0;
    p_zminutes = '0;
  endtask

  task automatic start_zone(input logic [7:0] c);
    p_zneg = (c == CH_MINUS);
    p_phase = PH_ZONE_H1;
  endtask

  task automatic parse_fixed_char(input logic [7:0] c, input bit dig, input int unsigned v);
    if (p_pos <= 3) begin
      if (dig) p_year = 14'(p_year * 10 + v);
      else p_failed = 1'b1;
    end else if (p_pos == 4 || p_pos == 7) begin
      if (c != CH_MINUS) p_failed = 1'b1;
    end else if (p_pos <= 6) begin
      if (dig) p_month = shift_in_digit(p_month, v);
      else p_failed = 1'b1;
    end else if (p_pos <= 9) begin
      if (dig) p_day = shift_in_digit(p_day, v);
      else p_failed = 1'b1;
    end else if (p_pos == 10) begin
      if (c != CH_T_UP && c != CH_T_LO && c != CH_SPACE) p_failed = 1'b1;
    end else if (p_pos == 13 || p_pos == 16) begin
      if (c != CH_COLON) p_failed = 1'b1;
    end else if (p_pos <= 12) begin
      if (dig) p_hour = shift_in_digit(p_hour, v);
      else p_failed = 1'b1;
    end else if (p_pos <= 15) begin
      if (dig) p_minute = shift_in_digit(p_minute, v);
      else p_failed = 1'b1;
    end else begin
      if (dig) p_second = shift_in_digit(p_second, v);
      else p_failed = 1'b1;
    end
    if (p_pos == 18) p_phase = PH_AFTER_SEC;
  endtask

  task automatic parse_tail_char(input logic [7:0] c, input bit dig, input int unsigned v);
    bit sgn;
    sgn = (c == CH_PLUS || c == CH_MINUS);
    case (p_phase)
      PH_AFTER_SEC: begin
        if (c == CH_DOT) p_phase = PH_FRACTION;
        else if (sgn) start_zone(c);
        else p_phase = PH_IGNORE;
      end
      PH_FRACTION: begin
        if (dig) begin
          case (p_place)
            2'd0:    p_millis = 10'(p_millis + v * 100);
            2'd1:    p_millis = 10'(p_millis + v * 10);
            2'd2:    p_millis = 10'(p_millis + v);
            default: ;
          endcase
          if (p_place < 3) p_place++;
        end else if (sgn) begin
          start_zone(c);
        end else begin
          p_phase = PH_IGNORE;
        end
      end
      PH_ZONE_H1, PH_ZONE_H2: begin
        if (dig) begin
          p_zhours = shift_in_digit(p_zhours, v);
          p_phase = (p_phase == PH_ZONE_H1) ? PH_ZONE_H2 : PH_ZONE_SEP;
        end else begin
          p_failed = 1'b1;
        end
      end
      PH_ZONE_SEP, PH_ZONE_M1: begin
        if (dig) begin
          p_zminutes = shift_in_digit(p_zminutes, v);
          p_phase = PH_ZONE_M2;
        end else if (c == CH_COLON && p_phase == PH_ZONE_SEP) begin
          p_phase = PH_ZONE_M1;
        end else begin
          p_phase = PH_IGNORE;
        end
      end
      PH_ZONE_M2: begin
        if (dig) begin
          p_zminutes = shift_in_digit(p_zminutes, v);
          p_phase = PH_IGNORE;
        end else begin
          p_failed = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // one accepted character; queues the stamp value when the string ends
  task automatic advance_parser(input logic [7:0] c, input logic is_last);
    epoch_result_t r;
    longint ms;
    bit dig;
    int unsigned v;
    dig = (c >= CH_ZERO && c <= CH_NINE);
    v = c - CH_ZERO;
    if (!p_failed) begin
      if (p_phase == PH_FIXED) parse_fixed_char(c, dig, v);
      else parse_tail_char(c, dig, v);
    end
    if (p_pos < 31) p_pos++;
    if (is_last) begin
      r.ok = !p_failed && p_phase != PH_FIXED && p_phase != PH_ZONE_H1 &&
             p_phase != PH_ZONE_H2 && p_phase != PH_ZONE_M2;
      ms = -1;
      if (r.ok) r.ok = epoch_from_fields(ms);
      r.ms = r.ok ? ms[EpW-1:0] : '1;
      pending_stamps.push_back(r);
      clear_parser();
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    int r;
    gap = 0;
    if (!quiet) begin
      r = $urandom_range(0, 99);
      if (r >= 96) gap = $urandom_range(10, 40);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    last_i     <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    advance_parser(c, is_last);
  endtask

  task automatic send_text_q();
    int i;
    for (i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    int i;
    text_q.delete();
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text_q();
  endtask

  task automatic push_num(input int v, input int nd);
    int k;
    int dv;
    dv = 1;
    for (k = 1; k < nd; k++) dv = dv * 10;
    for (k = 0; k < nd; k++) begin
      text_q.push_back(8'(CH_ZERO + (v / dv) % 10));
      dv = dv / 10;
    end
  endtask

  // mostly in range, sometimes any two-digit value
  function automatic int pick_field(int lo, int hi);
    if ($urandom_range(0, 99) < 85) return $urandom_range(lo, hi);
    return $urandom_range(0, 99);
  endfunction

  task automatic build_stamp();
    int yr, k, n;
    logic [7:0] sep[3];
    sep[0] = CH_T_UP;
    sep[1] = CH_T_LO;
    sep[2] = CH_SPACE;
    text_q.delete();
    yr = ($urandom_range(0, 3) == 0) ? $urandom_range(1968, 1971) : $urandom_range(0, 9999);
    push_num(yr, 4);
    text_q.push_back(CH_MINUS);
    push_num(pick_field(1, 12), 2);
    text_q.push_back(CH_MINUS);
    push_num(pick_field(1, 31), 2);
    text_q.push_back(sep[$urandom_range(0, 2)]);
    push_num(pick_field(0, 23), 2);
    text_q.push_back(CH_COLON);
    push_num(pick_field(0, 59), 2);
    text_q.push_back(CH_COLON);
    push_num(pick_field(0, 59), 2);
    if ($urandom_range(0, 1) == 1) begin
      text_q.push_back(CH_DOT);
      n = $urandom_range(0, 6);
      for (k = 0; k < n; k++) push_num($urandom_range(0, 9), 1);
    end
    if ($urandom_range(0, 1) == 1) begin
      text_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      push_num(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 14), 2);
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          text_q.push_back(CH_COLON);
          push_num(pick_field(0, 59), 2);
        end
        2: push_num(pick_field(0, 59), 2);
        default: text_q.push_back(CH_COLON);
      endcase
    end
    case ($urandom_range(0, 7))
      0: text_q.push_back(CH_Z_UP);
      1: begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) text_q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endtask

  task automatic test_plain_stamps();
    quiet = 1'b1;
    send_text("1970-01-01T00:00:00");
    send_text("2024-02-29t12:34:56Z");
    send_text("2000-03-01 00:00:00");
    send_text("1999-12-31T23:59:60");
    quiet = 1'b0;
  endtask

  // local time one second before the epoch is refused, zone or not; the same instant reached through a zone is not
  task automatic test_minus_one_second();
    send_text("1969-12-31T23:59:59");
    send_text("1969-12-31T23:59:59.999");
    send_text("1969-12-31T23:59:59+01:00");
    send_text("1969-12-31T23:59:58");
    send_text("1970-01-01T00:59:59+01:00");
  endtask

  task automatic test_field_extremes();
    send_text("0000-01-01T00:00:00");
    send_text("0000-00-00T00:00:00");
    send_text("9999-12-31T23:59:59.999+23:59");
    send_text("9999-99-99T99:99:99.999-99:99");
    send_text("0000-00-00T00:00:00.000+99:99");
  endtask

  task automatic test_malformed();
    send_text("2");
    send_text("2024-01-01T00:00:0");
    send_text("2024/01-01T00:00:00");
    send_text("2024-01-01X00:00:00");
    send_text("2024-01-01T00;00:00");
    send_text("20a4-01-01T00:00:00");
    send_text("x024-01-01T00:00:0a trailing");
  endtask

  task automatic test_fraction();
    send_text("2024-01-01T00:00:00.");
    send_text("2024-01-01T00:00:00.5");
    send_text("2024-01-01T00:00:00.12 tail");
    send_text("2024-01-01T00:00:00.1234567");
    send_text("2024-01-01T00:00:00.9+01");
  endtask

  task automatic test_zone();
    send_text("2024-01-01T00:00:00+");
    send_text("2024-01-01T00:00:00+1");
    send_text("2024-01-01T00:00:00+1x");
    send_text("2024-01-01T00:00:00-01:");
    send_text("2024-01-01T00:00:00+01:x tail");
    send_text("2024-01-01T00:00:00+013");
    send_text("2024-01-01T00:00:00+01:3x");
    send_text("2024-01-01T00:00:00+0130 tail");
    send_text("2024-01-01T00:00:00-01:30");
    send_text("2024-01-01T00:00:00+01x");
  endtask

  // output held off while strings keep arriving, so the input backs up
  task automatic test_output_hold();
    // nothing offered while waiting for the hold to begin
    in_valid_i <= 1'b0;
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk_i);
    send_text("2001-09-09T01:46:40.123+02:00");
    send_text("2038-01-19T03:14:07");
    send_text("1969-07-20T20:17:40-05");
    send_text("2000-02-30T25:61:61.5");
    send_text("bad");
  endtask

  task automatic test_random_stamps();
    int n_chars, n_stamps, kind, n, k;
    n_chars = 0;
    n_stamps = 0;
    while (n_chars < RAND_CHARS || n_stamps < RAND_STAMPS) begin
      if (n_stamps % 8 == 0) quiet = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        text_q.delete();
        n = $urandom_range(1, 24);
        for (k = 0; k < n; k++) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_stamp();
        if (kind == 7) begin
          text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (kind == 8) begin
          n = $urandom_range(1, text_q.size());
          while (text_q.size() > n) void'(text_q.pop_back());
        end
      end
      n_chars += text_q.size();
      n_stamps++;
      send_text_q();
    end
    quiet = 1'b0;
  endtask

  // receiver pacing, plus the long hold requested by the test
  initial begin
    int r, len;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall_i <= 1'b0;
          len = $urandom_range(1, 20);
        end else if (r < 92) begin
          out_stall_i <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          len = $urandom_range(15, 40);
        end
        repeat (len) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stamps.size() == 0) begin
        $error("unexpected result: valid_res %0d epoch_ms %0d", valid_res_o, epoch_ms_o);
        err_count++;
      end else begin
        seen_want = pending_stamps.pop_front();
        if (valid_res_o !== seen_want.ok) begin
          $error("valid_res mismatch: expected %0d, actual %0d", seen_want.ok, valid_res_o);
          err_count++;
        end
        if (epoch_ms_o !== seen_want.ms) begin
          $error("epoch_ms mismatch: expected %0d, actual %0d", seen_want.ms, epoch_ms_o);
          err_count++;
        end
      end
    end
  end

  // no progress on either side for too long means the block hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    ch_i        = '0;
    last_i      = 1'b0;
    out_stall_i = 1'b0;
    err_count   = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    hold_active = 1'b0;
    clear_parser();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_stamps();
    test_minus_one_second();
    test_field_extremes();
    test_malformed();
    test_fraction();
    test_zone();
    test_output_hold();
    test_random_stamps();

    in_valid_i <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== iso8601_text_to_epoch_ms_top.f =====
sv/isoep_pkg.sv
sv/isoep_parse.sv
sv/isoep_conv.sv
sv/isoep_ctrl.sv
sv/iso8601_text_to_epoch_ms_top.sv
tb/iso8601_text_to_epoch_ms_top_tb.sv
